>>> rtl/mss_pkg.sv
`default_nettype none

package mss_pkg;

  // table geometry
  localparam int SLOTS  = 8;
  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // field widths
  localparam int ID_W   = 32;
  localparam int CMD_W  = 2;
  localparam int STAT_W = 2;
  localparam int SIDX_W = 3;
  localparam int MASK_W = 8;

  // packed stream widths, padded to whole bytes
  localparam int IN_W   = 40;
  localparam int OUT_W  = 16;

  // command codes
  localparam logic [CMD_W-1:0] CMD_TOUCH = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PURGE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  // result status codes
  localparam logic [STAT_W-1:0] STAT_HIT      = 2'd0;
  localparam logic [STAT_W-1:0] STAT_INSERTED = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_DONE     = 2'd3;

  // identifier that gets the reserved flag on insert
  localparam logic signed [ID_W-1:0] RESERVED_ID = 32'sd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic scan;
    logic apply;
    logic emit;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_touch;
    logic scan_done;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

>>> rtl/mark_sweep_slot_table.sv
// Slot table with mark-and-sweep housekeeping.
// Input channel s_*: one request per handshake, tdata = command[1:0], id[33:2].
//   touch looks the id up in the slots; a hit sets its mark, a miss writes it into
//   the first empty slot (marked, reserved only for id 1); no empty slot reports full.
//   purge empties every unmarked slot; clear drops all marks.
// Output channel m_*: one result per request, tdata = status[1:0], slot_index[4:2],
//   slot_reserved[5], occupied_mask[13:6].
// cfg_wr_en/cfg_wr_data load the empty marker; write only while no request is open.
// Sequence: a touch scans one slot per cycle from slot 0 and stops at the first match
//   or at the last slot, then passes through apply and emit; the result is
//   registered at emit. purge and clear skip the scan and work on all slots at
//   once. The scan pointer over the slot comparator sets the touch time.
// One request is in work at a time; the result sits in an output register, so the
//   next request is taken while the result waits. A stalled receiver holds the
//   result and blocks only the end of the following request.
// Reset: synchronous, clears the marker to 0, all slots to 0 and all flags.
`default_nettype none

module mark_sweep_slot_table (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // empty marker register
  input  wire logic                       cfg_wr_en,
  input  wire logic [mss_pkg::ID_W-1:0]   cfg_wr_data,
  // requests
  input  wire logic                       s_tvalid,
  output logic                            s_tready,
  input  wire logic [mss_pkg::IN_W-1:0]   s_tdata,   // command, id
  // results
  output logic                            m_tvalid,
  input  wire logic                       m_tready,
  output logic      [mss_pkg::OUT_W-1:0]  m_tdata    // status, slot_index, slot_reserved,
                                                     // occupied_mask
);
  import mss_pkg::*;

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  // sequencer
  mss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  // slot storage, scan and result register
  mss_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (s_tdata),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_data    (m_tdata),
    .cmd         (dp_cmd),
    .stat        (dp_stat)
  );

endmodule

`default_nettype wire

>>> rtl/mss_ctrl.sv
`default_nettype none

module mss_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire mss_pkg::dp_stat_t stat,
  output mss_pkg::dp_cmd_t       cmd
);
  import mss_pkg::*;

  state_t state, state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = stat.in_touch ? ST_SCAN : ST_APPLY;
        end
      end
      ST_SCAN: begin
        if (stat.scan_done) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
      end
      ST_APPLY: begin
        cmd.apply = 1'b1;
      end
      ST_EMIT: begin
        cmd.emit = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/mss_datapath.sv
`default_nettype none

module mss_datapath (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_wr_en,
  input  wire logic [mss_pkg::ID_W-1:0]   cfg_wr_data,
  input  wire logic [mss_pkg::IN_W-1:0]   in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic      [mss_pkg::OUT_W-1:0]  out_data,
  input  wire mss_pkg::dp_cmd_t           cmd,
  output mss_pkg::dp_stat_t               stat
);
  import mss_pkg::*;

  // unpacked request fields
  logic        [CMD_W-1:0] in_cmd;
  logic signed [ID_W-1:0]  in_id;

  // captured request
  logic        [CMD_W-1:0] cmd_q;
  logic signed [ID_W-1:0]  id_q;

  // table state
  logic signed [ID_W-1:0]  marker;
  logic signed [ID_W-1:0]  ids [SLOTS];
  logic                    resv [SLOTS];
  logic                    marks [SLOTS];

  // scan state
  logic [IDX_W-1:0]        cnt;
  logic                    hit_found;
  logic                    free_found;
  logic [IDX_W-1:0]        free_idx;

  // result of the current request
  logic [STAT_W-1:0]       res_status;
  logic [IDX_W-1:0]        res_idx;
  logic                    res_resv;

  logic                    match_now;
  logic                    empty_now;
  logic                    cnt_last;
  logic [MASK_W-1:0]       occ_mask;

  assign in_cmd = in_data[CMD_W-1:0];
  assign in_id  = in_data[CMD_W+ID_W-1:CMD_W];

  // compare of the slot under the scan pointer
  assign match_now = (ids[cnt] == id_q);
  assign empty_now = (ids[cnt] == marker);
  assign cnt_last  = (cnt == IDX_W'(SLOTS - 1));

  assign stat.in_touch  = (in_cmd == CMD_TOUCH);
  assign stat.scan_done = match_now || cnt_last;
  assign stat.out_free  = !out_valid || out_ready;

  // occupancy of the low slots against the current marker
  for (genvar g = 0; g < MASK_W; g++) begin : g_occ
    if (g < SLOTS) begin : g_slot
      assign occ_mask[g] = (ids[g] != marker);
    end else begin : g_none
      assign occ_mask[g] = 1'b0;
    end
  end

  // request capture, scan pointers and result fields
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_q <= in_cmd;
      id_q  <= in_id;
    end
    if (cmd.scan && !free_found && !match_now && empty_now) begin
      free_idx <= cnt;
    end
    if (cmd.apply) begin
      res_status <= STAT_DONE;
      res_idx    <= '0;
      res_resv   <= 1'b0;
      if (cmd_q == CMD_TOUCH) begin
        if (hit_found) begin
          res_status <= STAT_HIT;
          res_idx    <= cnt;
          res_resv   <= resv[cnt];
        end else if (free_found) begin
          res_status <= STAT_INSERTED;
          res_idx    <= free_idx;
          res_resv   <= (id_q == RESERVED_ID);
        end else begin
          res_status <= STAT_FULL;
        end
      end
    end
    if (cmd.emit) begin
      out_data <= {{(OUT_W - STAT_W - SIDX_W - 1 - MASK_W){1'b0}},
                   occ_mask, res_resv, SIDX_W'(res_idx), res_status};
    end
  end

  // scan control, marker register and table contents
  always_ff @(posedge clk) begin
    if (rst) begin
      marker     <= '0;
      cnt        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        ids[i]   <= '0;
        resv[i]  <= 1'b0;
        marks[i] <= 1'b0;
      end
    end else begin
      if (cfg_wr_en) begin
        marker <= cfg_wr_data;
      end

      if (cmd.load) begin
        cnt        <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
      end else if (cmd.scan) begin
        if (match_now) begin
          hit_found <= 1'b1;
        end else begin
          if (empty_now) begin
            free_found <= 1'b1;
          end
          if (!cnt_last) begin
            cnt <= cnt + 1'b1;
          end
        end
      end

      // table update
      if (cmd.apply) begin
        case (cmd_q)
          CMD_TOUCH: begin
            if (hit_found) begin
              marks[cnt] <= 1'b1;
            end else if (free_found) begin
              ids[free_idx]   <= id_q;
              resv[free_idx]  <= (id_q == RESERVED_ID);
              marks[free_idx] <= 1'b1;
            end
          end
          CMD_PURGE: begin
            for (int i = 0; i < SLOTS; i++) begin
              if (!marks[i]) begin
                ids[i]  <= marker;
                resv[i] <= 1'b0;
              end
            end
          end
          CMD_CLEAR: begin
            for (int i = 0; i < SLOTS; i++) begin
              marks[i] <= 1'b0;
            end
          end
          default: begin
          end
        endcase
      end

      // output register
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/mss_checker.sv
`default_nettype none

module mss_checker (
  input wire logic                      clk,
  input wire logic                      rst,
  input wire logic                      s_tvalid,
  input wire logic                      s_tready,
  input wire logic                      m_tvalid,
  input wire logic                      m_tready,
  input wire logic [mss_pkg::OUT_W-1:0] m_tdata
);
  import mss_pkg::*;

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed under stall");

  // one request at a time: no accept right after an accept
  a_one_open: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while another is open");

  // a result never shows up the cycle after an accept
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result too early");

  // full and done carry no slot
  a_no_slot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[1:0] == STAT_FULL || m_tdata[1:0] == STAT_DONE)
      |-> m_tdata[5:2] == 4'd0)
    else $error("slot fields set without a touch hit or insert");

  // reset empties the output
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind mark_sweep_slot_table mss_checker u_mss_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire

>>> tb/tb_mark_sweep_slot_table.sv
`default_nettype none

module tb_mark_sweep_slot_table;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  // command code that the block does not use
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int STALL_LIMIT = 5000;
  localparam int LONG_HOLD   = 300;
  localparam int RAND_PHASES = 5;
  localparam int PHASE_ITEMS = 136;
  localparam int POOL_N      = 12;
  localparam int SETTLE      = 12;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [ID_W-1:0]  id;
  } slot_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [SIDX_W-1:0] slot;
    logic              resv;
    logic [MASK_W-1:0] mask;
  } slot_result_t;

  // dut ports
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_wr_en = 1'b0;
  logic [ID_W-1:0]   cfg_wr_data = '0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;   // command, id, zero pad
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;        // status, slot_index, slot_reserved, occupied_mask, pad

  // shadow copy of the slot table
  logic [ID_W-1:0]   slot_id   [SLOTS];
  logic              slot_resv [SLOTS];
  logic              slot_mark [SLOTS];
  logic [ID_W-1:0]   cur_marker = '0;

  slot_req_t         pending_reqs[$];
  slot_result_t      expected_results[$];
  logic [ID_W-1:0]   id_pool [POOL_N];

  // handshake flags seen at the last rising edge
  logic              req_taken = 1'b0;
  logic              res_taken = 1'b0;

  int                src_idle_max = 0;
  int                snk_idle_max = 0;
  int                send_gap = 0;
  int                sink_wait = 0;
  int                hold_token = 0;
  int                hold_seen = 0;
  int                hold_left = 0;
  int                idle_cycles = 0;
  int                err_count = 0;
  int                n_hit = 0;
  int                n_ins = 0;
  int                n_full = 0;
  int                n_done = 0;
  int                n_marker_writes = 0;

  mark_sweep_slot_table u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // apply one request to the shadow table and return what the block should report
  function automatic slot_result_t table_step(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] id);
    slot_result_t r;
    int i;
    int hit_at;
    int free_at;
    r.status = STAT_DONE;
    r.slot   = '0;
    r.resv   = 1'b0;
    r.mask   = '0;
    hit_at   = -1;
    free_at  = -1;
    if (cmd == CMD_TOUCH) begin
      // scan stops at the first match; note the first empty slot on the way
      for (i = 0; i < SLOTS; i++) begin
        if (hit_at < 0) begin
          if (slot_id[i] == id) hit_at = i;
          else if (slot_id[i] == cur_marker && free_at < 0) free_at = i;
        end
      end
      if (hit_at >= 0) begin
        slot_mark[hit_at] = 1'b1;
        r.status = STAT_HIT;
        r.slot   = hit_at[SIDX_W-1:0];
        r.resv   = slot_resv[hit_at];
      end else if (free_at >= 0) begin
        slot_id[free_at]   = id;
        slot_resv[free_at] = (id == RESERVED_ID);
        slot_mark[free_at] = 1'b1;
        r.status = STAT_INSERTED;
        r.slot   = free_at[SIDX_W-1:0];
        r.resv   = slot_resv[free_at];
      end else begin
        r.status = STAT_FULL;
      end
    end else if (cmd == CMD_PURGE) begin
      for (i = 0; i < SLOTS; i++) begin
        if (!slot_mark[i]) begin
          slot_id[i]   = cur_marker;
          slot_resv[i] = 1'b0;
        end
      end
    end else if (cmd == CMD_CLEAR) begin
      for (i = 0; i < SLOTS; i++) slot_mark[i] = 1'b0;
    end
    // emptiness is judged against the current marker
    for (i = 0; i < SLOTS && i < MASK_W; i++) r.mask[i] = (slot_id[i] != cur_marker);
    return r;
  endfunction

  // request driver
  always @(negedge clk) begin
    slot_req_t nxt;
    if (!s_tvalid || req_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        nxt = pending_reqs.pop_front();
        s_tdata  <= {{(IN_W-CMD_W-ID_W){1'b0}}, nxt.id, nxt.cmd};
        s_tvalid <= 1'b1;
        send_gap = $urandom_range(src_idle_max, 0);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result receiver with random stalls and an occasional long hold-off
  always @(negedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen = hold_token;
      hold_left = LONG_HOLD;
    end
    if (res_taken) sink_wait = $urandom_range(snk_idle_max, 0);
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (sink_wait > 0) begin
      sink_wait--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on each accepted request, check each accepted result
  always @(posedge clk) begin
    slot_result_t got;
    slot_result_t want;
    req_taken = 1'b0;
    res_taken = 1'b0;
    if (!rst) begin
      idle_cycles++;
      if (s_tvalid && s_tready) begin
        req_taken   = 1'b1;
        idle_cycles = 0;
        want = table_step(s_tdata[CMD_W-1:0], s_tdata[CMD_W+ID_W-1:CMD_W]);
        expected_results.push_back(want);
        case (want.status)
          STAT_HIT:      n_hit++;
          STAT_INSERTED: n_ins++;
          STAT_FULL:     n_full++;
          default:       n_done++;
        endcase
      end
      if (m_tvalid && m_tready) begin
        res_taken   = 1'b1;
        idle_cycles = 0;
        got.status = m_tdata[STAT_W-1:0];
        got.slot   = m_tdata[STAT_W+SIDX_W-1:STAT_W];
        got.resv   = m_tdata[STAT_W+SIDX_W];
        got.mask   = m_tdata[STAT_W+SIDX_W+MASK_W:STAT_W+SIDX_W+1];
        if (expected_results.size() == 0) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: result with nothing pending: status=%0d slot=%0d resv=%0d mask=%02h",
                     $realtime, got.status, got.slot, got.resv, got.mask);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.slot !== want.slot ||
              got.resv !== want.resv || got.mask !== want.mask) begin
            err_count++;
            if (err_count <= 10)
              $display({"%0t: mismatch exp status=%0d slot=%0d resv=%0d mask=%02h",
                        " got status=%0d slot=%0d resv=%0d mask=%02h"}, $realtime,
                       want.status, want.slot, want.resv, want.mask,
                       got.status, got.slot, got.resv, got.mask);
          end
        end
      end
    end
  end

  // watchdog
  initial begin
    while (idle_cycles < STALL_LIMIT) @(negedge clk);
    $display("no request or result moved for %0d cycles", STALL_LIMIT);
    $display("FAILURE");
    $finish;
  end

  task automatic push_req(input logic [CMD_W-1:0] c, input logic [ID_W-1:0] v);
    slot_req_t q;
    q.cmd = c;
    q.id  = v;
    pending_reqs.push_back(q);
  endtask

  // wait until every request is sent and answered, then let the block settle
  task automatic drain();
    while (pending_reqs.size() != 0 || s_tvalid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_marker(input logic [ID_W-1:0] v);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    cur_marker = v;
    n_marker_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // mostly touches from a small id pool so hits, inserts and full drops all happen
  task automatic queue_random_phase(input int count);
    int k;
    int r;
    for (k = 0; k < POOL_N; k++) id_pool[k] = $urandom;
    id_pool[0] = RESERVED_ID;
    id_pool[1] = cur_marker;
    id_pool[2] = '0;
    for (k = 0; k < count; k++) begin
      r = $urandom_range(99, 0);
      if (r < 70)      push_req(CMD_TOUCH, id_pool[$urandom_range(POOL_N-1, 0)]);
      else if (r < 78) push_req(CMD_TOUCH, $urandom);
      else if (r < 87) push_req(CMD_CLEAR, $urandom);
      else if (r < 96) push_req(CMD_PURGE, $urandom);
      else             push_req(CMD_UNUSED, $urandom);
    end
  endtask

  // stimulus
  initial begin
    int p;
    for (p = 0; p < SLOTS; p++) begin
      slot_id[p]   = '0;
      slot_resv[p] = 1'b0;
      slot_mark[p] = 1'b0;
    end
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed part with the reset marker of zero
    src_idle_max = 2;
    snk_idle_max = 2;
    push_req(CMD_TOUCH, 32'h0000_0000);   // touch of the empty marker
    push_req(CMD_TOUCH, 32'h0000_0001);   // reserved id
    push_req(CMD_TOUCH, 32'h7FFF_FFFF);
    push_req(CMD_TOUCH, 32'h8000_0000);
    push_req(CMD_TOUCH, 32'hFFFF_FFFF);
    push_req(CMD_TOUCH, 32'h0000_0001);   // hit on reserved slot
    push_req(CMD_TOUCH, 32'h0000_0005);
    push_req(CMD_TOUCH, 32'h0000_0006);
    push_req(CMD_TOUCH, 32'h0000_0007);
    push_req(CMD_TOUCH, 32'h0000_0008);
    push_req(CMD_TOUCH, 32'h0000_0009);   // table full
    push_req(CMD_TOUCH, 32'h0000_0000);   // marker with no empty slot
    push_req(CMD_UNUSED, 32'h0000_0000);
    push_req(CMD_CLEAR, 32'hFFFF_FFFF);
    push_req(CMD_TOUCH, 32'h7FFF_FFFF);
    push_req(CMD_PURGE, 32'h0000_0000);   // keeps only the marked slot
    push_req(CMD_TOUCH, 32'h0000_0001);
    push_req(CMD_TOUCH, 32'hAAAA_AAAA);
    push_req(CMD_CLEAR, 32'h0000_0000);
    push_req(CMD_PURGE, 32'h0000_0000);   // empties everything
    push_req(CMD_UNUSED, 32'h5555_5555);
    drain();

    // marker moves: slots still holding zero now count as occupied
    write_marker(32'h8000_0000);
    push_req(CMD_TOUCH, 32'h0000_0000);
    push_req(CMD_TOUCH, 32'h8000_0000);
    push_req(CMD_PURGE, 32'h0000_0000);
    push_req(CMD_TOUCH, 32'h8000_0000);
    drain();

    // random phases, each with its own marker and idling pattern
    for (p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin src_idle_max = 9; snk_idle_max = 9; end
        1: begin src_idle_max = 0; snk_idle_max = 0; write_marker(32'h7FFF_FFFF); end
        2: begin src_idle_max = 0; snk_idle_max = 9; write_marker(32'hFFFF_FFFF); end
        3: begin src_idle_max = 9; snk_idle_max = 0; write_marker($urandom); end
        default: begin src_idle_max = 9; snk_idle_max = 9; write_marker(32'h0000_0000); end
      endcase
      queue_random_phase(PHASE_ITEMS);
      // receiver holds off while the sender keeps offering requests
      if (p == 2) hold_token++;
      drain();
    end

    if (expected_results.size() != 0)
      $display("%0d results never arrived", expected_results.size());
    $display("covered %0d requests: %0d hits, %0d inserts, %0d full drops, %0d purge/clear/other",
             n_hit + n_ins + n_full + n_done, n_hit, n_ins, n_full, n_done);
    $display("empty marker rewritten %0d times incl. both signed extremes, %0d long result hold-off",
             n_marker_writes, hold_token);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", err_count);
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
rtl/mss_pkg.sv
rtl/mss_ctrl.sv
rtl/mss_datapath.sv
rtl/mark_sweep_slot_table.sv
rtl/mss_checker.sv
tb/tb_mark_sweep_slot_table.sv
